>>> rtl/atce_pkg.sv
// Shared types and constants for the escape sequence text cursor engine.
package atce_pkg;

	localparam int BYTE_W  = 8;
	localparam int POS_W   = 10;
	localparam int COLOR_W = 4;
	localparam int APB_AW  = 4;
	localparam int APB_DW  = 32;

	localparam logic [POS_W-1:0] POS_MAX = 10'd1023;

	localparam logic [BYTE_W-1:0] BYTE_ESC   = 8'h1B;
	localparam logic [BYTE_W-1:0] BYTE_LF    = 8'h0A;
	localparam logic [BYTE_W-1:0] BYTE_CSI   = 8'h5B;
	localparam logic [BYTE_W-1:0] BYTE_PRIV  = 8'h3F;
	localparam logic [BYTE_W-1:0] BYTE_H     = 8'h48;
	localparam logic [BYTE_W-1:0] BYTE_M     = 8'h6D;
	localparam logic [BYTE_W-1:0] BYTE_J     = 8'h4A;
	localparam logic [BYTE_W-1:0] DIGIT_LO   = 8'h30;
	localparam logic [BYTE_W-1:0] DIGIT_HI   = 8'h39;
	localparam logic [BYTE_W-1:0] PARAM_HI   = 8'h3F;

	localparam logic [POS_W-1:0] SGR_FG_LO    = 10'd30;
	localparam logic [POS_W-1:0] SGR_FG_HI    = 10'd37;
	localparam logic [POS_W-1:0] SGR_BG_LO    = 10'd40;
	localparam logic [POS_W-1:0] SGR_BG_HI    = 10'd47;
	localparam logic [POS_W-1:0] SGR_FG_BR_LO = 10'd90;
	localparam logic [POS_W-1:0] SGR_FG_BR_HI = 10'd97;
	localparam logic [POS_W-1:0] SGR_BG_BR_LO = 10'd100;
	localparam logic [POS_W-1:0] SGR_BG_BR_HI = 10'd107;
	// bright codes map to index 8-15: code - 90 + 8, code - 100 + 8
	localparam logic [POS_W-1:0] SGR_FG_BR_OFS = 10'd82;
	localparam logic [POS_W-1:0] SGR_BG_BR_OFS = 10'd92;

	localparam logic [POS_W-1:0]   HOME_COL_RST = 10'd1;
	localparam logic [POS_W-1:0]   HOME_ROW_RST = 10'd1;
	localparam logic [COLOR_W-1:0] FORE_RST     = 4'd7;
	localparam logic [COLOR_W-1:0] BACK_RST     = 4'd0;

	localparam logic EVT_DRAW  = 1'b0;
	localparam logic EVT_CLEAR = 1'b1;

	typedef enum logic [1:0] {
		MODE_TEXT,
		MODE_ESC,
		MODE_CSI,
		MODE_PRIV
	} mode_t;

	typedef enum logic [2:0] {
		OP_DRAW,
		OP_NEWLINE,
		OP_CURSOR,
		OP_FORE,
		OP_BACK,
		OP_CLEAR
	} op_t;

	typedef enum logic [1:0] {
		REG_HOME_COL,
		REG_HOME_ROW,
		REG_DEF_FORE,
		REG_DEF_BACK
	} reg_idx_t;

	typedef struct packed {
		op_t              op;
		logic [POS_W-1:0] val_a;
		logic [POS_W-1:0] val_b;
	} cmd_t;

	typedef struct packed {
		logic               kind;
		logic [BYTE_W-1:0]  glyph;
		logic [POS_W-1:0]   column;
		logic [POS_W-1:0]   row_pos;
		logic [COLOR_W-1:0] fore;
		logic [COLOR_W-1:0] back;
	} res_t;

endpackage

>>> rtl/ansi_escape_text_cursor_engine.sv
// Top level: escape sequence parser, command queue, cursor unit and register port.
//
//  channel   direction  handshake            payload
//  input     in         push / full          byte_in
//  result    out        empty / pop          event_kind glyph column row_pos
//                                            fore_index back_index
//  config    in         psel penable pwrite  paddr pwdata, prdata back, pready tied high
//
// One byte per cycle while full is low; the back end retires one queued command per
// cycle while no held result stalls it. A byte is decoded in the cycle it is taken;
// its command passes through the queue and the back end to the output register.
// Reset clears parser state, arguments, cursor, colors and the queue; no sweep needed.
// A held result stalls a drawing or clear command at the queue head and all behind it;
// full rises once two commands wait in the queue.
module ansi_escape_text_cursor_engine import atce_pkg::*; #(
	parameter int ARG_DIGITS = 3,
	parameter int MAX_ARGS   = 4
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [APB_AW-1:0]  paddr,
	input  logic [APB_DW-1:0]  pwdata,
	output logic [APB_DW-1:0]  prdata,
	output logic               pready,
	input  logic               push,
	output logic               full,
	input  logic [BYTE_W-1:0]  byte_in,
	output logic               empty,
	input  logic               pop,
	output logic               event_kind,
	output logic [BYTE_W-1:0]  glyph,
	output logic [POS_W-1:0]   column,
	output logic [POS_W-1:0]   row_pos,
	output logic [COLOR_W-1:0] fore_index,
	output logic [COLOR_W-1:0] back_index
);

	logic [POS_W-1:0]   home_col_q, home_row_q;
	logic [COLOR_W-1:0] def_fore_q, def_back_q;
	logic               cfg_wr, accept, cmd_push, q_valid, q_pop, res_valid;
	reg_idx_t           reg_sel;
	cmd_t               cmd_in, cmd_head;
	res_t               res;

	// register port
	assign pready  = 1'b1;
	assign reg_sel = reg_idx_t'(paddr[3:2]);
	assign cfg_wr  = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			home_col_q <= HOME_COL_RST;
			home_row_q <= HOME_ROW_RST;
			def_fore_q <= FORE_RST;
			def_back_q <= BACK_RST;
		end else if (cfg_wr) begin
			case (reg_sel)
				REG_HOME_COL: home_col_q <= pwdata[POS_W-1:0];
				REG_HOME_ROW: home_row_q <= pwdata[POS_W-1:0];
				REG_DEF_FORE: def_fore_q <= pwdata[COLOR_W-1:0];
				REG_DEF_BACK: def_back_q <= pwdata[COLOR_W-1:0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		case (reg_sel)
			REG_HOME_COL: prdata = {{(APB_DW-POS_W){1'b0}}, home_col_q};
			REG_HOME_ROW: prdata = {{(APB_DW-POS_W){1'b0}}, home_row_q};
			REG_DEF_FORE: prdata = {{(APB_DW-COLOR_W){1'b0}}, def_fore_q};
			REG_DEF_BACK: prdata = {{(APB_DW-COLOR_W){1'b0}}, def_back_q};
			default:      prdata = '0;
		endcase
	end

	assign accept = push && !full;

	atce_front #(
		.ARG_DIGITS(ARG_DIGITS),
		.MAX_ARGS  (MAX_ARGS)
	) u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.accept  (accept),
		.byte_in (byte_in),
		.cmd_push(cmd_push),
		.cmd     (cmd_in)
	);

	atce_cmd_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (cmd_push),
		.wr_data (cmd_in),
		.full    (full),
		.rd_en   (q_pop),
		.rd_valid(q_valid),
		.rd_data (cmd_head)
	);

	atce_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd_valid(q_valid),
		.cmd      (cmd_head),
		.cmd_pop  (q_pop),
		.home_col (home_col_q),
		.home_row (home_row_q),
		.pop      (pop),
		.res_valid(res_valid),
		.res      (res)
	);

	assign empty      = !res_valid;
	assign event_kind = res.kind;
	assign glyph      = res.glyph;
	assign column     = res.column;
	assign row_pos    = res.row_pos;
	assign fore_index = res.fore;
	assign back_index = res.back;

	// nothing queued and nothing shown: no result can appear in the next cycle
	a_no_spurious_result: assert property (@(posedge clk) disable iff (!arst_n)
		(empty && !q_valid) |=> empty)
		else $error("result appeared with no queued command");

	// a clear word carries no glyph and no position
	a_clear_word_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && event_kind == EVT_CLEAR) |-> (glyph == '0 && column == '0 && row_pos == '0))
		else $error("clear word with nonzero glyph or position");

	// input side cannot be blocked while the command queue is empty
	a_full_needs_queued: assert property (@(posedge clk) disable iff (!arst_n)
		!q_valid |-> !full)
		else $error("full raised with empty command queue");

endmodule

>>> rtl/atce_front.sv
// Front end: byte parser, argument collection and command decode.
module atce_front import atce_pkg::*; #(
	parameter int ARG_DIGITS = 3,
	parameter int MAX_ARGS   = 4
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              accept,
	input  logic [BYTE_W-1:0] byte_in,
	output logic              cmd_push,
	output cmd_t              cmd
);

	localparam int IDX_W = $clog2(MAX_ARGS);
	localparam int CNT_W = $clog2(MAX_ARGS + 2);
	localparam int PH_W  = (ARG_DIGITS > 1) ? $clog2(ARG_DIGITS) : 1;
	localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_ARGS);
	localparam logic [PH_W-1:0]  PH_LAST = PH_W'(ARG_DIGITS - 1);

	mode_t            mode_q, mode_d;
	logic [PH_W-1:0]  phase_q, phase_d;
	logic [CNT_W-1:0] count_q, cnt_new, cnt_m1;
	logic [POS_W-1:0] args_q [MAX_ARGS];

	logic             is_digit, in_range, end_seq, collect, arg_wr, cmd_hit;
	logic [IDX_W-1:0] arg_idx;
	logic [POS_W-1:0] base, arg_new, a0;
	logic [13:0]      acc;

	assign is_digit = (byte_in >= DIGIT_LO) && (byte_in <= DIGIT_HI);
	assign in_range = (byte_in >= DIGIT_LO) && (byte_in <= PARAM_HI);
	assign a0       = args_q[0];

	// next parse mode
	always_comb begin
		mode_d  = mode_q;
		end_seq = 1'b0;
		case (mode_q)
			MODE_TEXT: begin
				if (byte_in == BYTE_ESC) mode_d = MODE_ESC;
			end
			MODE_ESC: begin
				if (byte_in == BYTE_CSI) mode_d = MODE_CSI;
				else end_seq = 1'b1;
			end
			MODE_CSI: begin
				if (byte_in == BYTE_PRIV) mode_d = MODE_PRIV;
				else if (!in_range) end_seq = 1'b1;
			end
			MODE_PRIV: begin
				if (!in_range) end_seq = 1'b1;
			end
			default: begin
				end_seq = 1'b1;
			end
		endcase
		if (end_seq) mode_d = MODE_TEXT;
	end

	// command decode
	always_comb begin
		cmd_hit   = 1'b0;
		cmd.op    = OP_DRAW;
		cmd.val_a = {{(POS_W-BYTE_W){1'b0}}, byte_in};
		cmd.val_b = args_q[1];
		case (mode_q)
			MODE_TEXT: begin
				if (byte_in == BYTE_LF) begin
					cmd_hit = 1'b1;
					cmd.op  = OP_NEWLINE;
				end else if (byte_in != BYTE_ESC) begin
					cmd_hit = 1'b1;
				end
			end
			MODE_CSI: begin
				if (byte_in != BYTE_PRIV && !in_range) begin
					if (byte_in == BYTE_H) begin
						cmd_hit   = 1'b1;
						cmd.op    = OP_CURSOR;
						cmd.val_a = a0;
					end else if (byte_in == BYTE_J) begin
						cmd_hit = 1'b1;
						cmd.op  = OP_CLEAR;
					end else if (byte_in == BYTE_M) begin
						if (a0 >= SGR_FG_LO && a0 <= SGR_FG_HI) begin
							cmd_hit   = 1'b1;
							cmd.op    = OP_FORE;
							cmd.val_a = a0 - SGR_FG_LO;
						end else if (a0 >= SGR_BG_LO && a0 <= SGR_BG_HI) begin
							cmd_hit   = 1'b1;
							cmd.op    = OP_BACK;
							cmd.val_a = a0 - SGR_BG_LO;
						end else if (a0 >= SGR_FG_BR_LO && a0 <= SGR_FG_BR_HI) begin
							cmd_hit   = 1'b1;
							cmd.op    = OP_FORE;
							cmd.val_a = a0 - SGR_FG_BR_OFS;
						end else if (a0 >= SGR_BG_BR_LO && a0 <= SGR_BG_BR_HI) begin
							cmd_hit   = 1'b1;
							cmd.op    = OP_BACK;
							cmd.val_a = a0 - SGR_BG_BR_OFS;
						end
					end
				end
			end
			default: begin
			end
		endcase
	end

	assign cmd_push = accept && cmd_hit;

	// argument collection; digits only count inside a CSI sequence
	assign collect = (mode_q == MODE_CSI || mode_q == MODE_PRIV) && is_digit;
	assign cnt_new = (phase_q == '0 && count_q <= CNT_MAX) ? count_q + CNT_W'(1) : count_q;
	assign cnt_m1  = cnt_new - CNT_W'(1);
	assign arg_idx = cnt_m1[IDX_W-1:0];
	assign arg_wr  = collect && (cnt_new != '0) && (cnt_new <= CNT_MAX);
	assign base    = (phase_q == '0) ? '0 : args_q[arg_idx];
	assign acc     = ({4'b0, base} << 3) + ({4'b0, base} << 1) + {10'b0, byte_in[3:0]};
	assign arg_new = (acc > {4'b0, POS_MAX}) ? POS_MAX : acc[POS_W-1:0];
	assign phase_d = !collect ? '0 : (phase_q >= PH_LAST) ? '0 : phase_q + PH_W'(1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= MODE_TEXT;
			phase_q <= '0;
			count_q <= '0;
			for (int i = 0; i < MAX_ARGS; i++) args_q[i] <= '0;
		end else if (accept) begin
			mode_q  <= mode_d;
			phase_q <= phase_d;
			if (end_seq) count_q <= '0;
			else if (collect) count_q <= cnt_new;
			if (arg_wr) args_q[arg_idx] <= arg_new;
		end
	end

endmodule

>>> rtl/atce_cmd_queue.sv
// Two-word command queue between parser and cursor unit.
module atce_cmd_queue import atce_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic wr_en,
	input  cmd_t wr_data,
	output logic full,
	input  logic rd_en,
	output logic rd_valid,
	output cmd_t rd_data
);

	localparam int DEPTH = 2;
	localparam int AW    = $clog2(DEPTH);
	localparam int CW    = $clog2(DEPTH + 1);

	cmd_t          entries_q [DEPTH];
	logic [AW-1:0] wr_ptr_q, rd_ptr_q;
	logic [CW-1:0] count_q;
	logic          do_wr, do_rd;

	assign full     = (count_q == CW'(DEPTH));
	assign rd_valid = (count_q != '0);
	assign rd_data  = entries_q[rd_ptr_q];
	assign do_wr    = wr_en && !full;
	assign do_rd    = rd_en && rd_valid;

	always_ff @(posedge clk) begin
		if (do_wr) entries_q[wr_ptr_q] <= wr_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr) wr_ptr_q <= wr_ptr_q + AW'(1);
			if (do_rd) rd_ptr_q <= rd_ptr_q + AW'(1);
			if (do_wr && !do_rd) count_q <= count_q + CW'(1);
			else if (!do_wr && do_rd) count_q <= count_q - CW'(1);
		end
	end

endmodule

>>> rtl/atce_back.sv
// Back end: cursor and color state, result word register.
module atce_back import atce_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cmd_valid,
	input  cmd_t             cmd,
	output logic             cmd_pop,
	input  logic [POS_W-1:0] home_col,
	input  logic [POS_W-1:0] home_row,
	input  logic             pop,
	output logic             res_valid,
	output res_t             res
);

	logic [POS_W-1:0]   col_q, row_q;
	logic [COLOR_W-1:0] fore_q, back_q;
	logic               res_valid_q;
	res_t               res_q;
	logic               makes_res, slot_free, res_load;

	function automatic logic [POS_W-1:0] sat_inc(input logic [POS_W-1:0] v);
		return (v == POS_MAX) ? POS_MAX : v + POS_W'(1);
	endfunction

	assign makes_res = (cmd.op == OP_DRAW) || (cmd.op == OP_CLEAR);
	assign slot_free = !res_valid_q || pop;
	assign cmd_pop   = cmd_valid && (slot_free || !makes_res);
	assign res_load  = cmd_pop && makes_res;

	assign res_valid = res_valid_q;
	assign res       = res_q;

	always_ff @(posedge clk) begin
		if (res_load) begin
			res_q.fore <= fore_q;
			res_q.back <= back_q;
			if (cmd.op == OP_CLEAR) begin
				res_q.kind    <= EVT_CLEAR;
				res_q.glyph   <= '0;
				res_q.column  <= '0;
				res_q.row_pos <= '0;
			end else begin
				res_q.kind    <= EVT_DRAW;
				res_q.glyph   <= cmd.val_a[BYTE_W-1:0];
				res_q.column  <= col_q;
				res_q.row_pos <= row_q;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q       <= HOME_COL_RST;
			row_q       <= HOME_ROW_RST;
			fore_q      <= FORE_RST;
			back_q      <= BACK_RST;
			res_valid_q <= 1'b0;
		end else begin
			if (res_load) res_valid_q <= 1'b1;
			else if (pop) res_valid_q <= 1'b0;
			if (cmd_pop) begin
				case (cmd.op)
					OP_DRAW: begin
						col_q <= sat_inc(col_q);
					end
					OP_NEWLINE: begin
						col_q <= home_col;
						row_q <= sat_inc(row_q);
					end
					OP_CURSOR: begin
						col_q <= cmd.val_a;
						row_q <= cmd.val_b;
					end
					OP_FORE: begin
						fore_q <= cmd.val_a[COLOR_W-1:0];
					end
					OP_BACK: begin
						back_q <= cmd.val_a[COLOR_W-1:0];
					end
					OP_CLEAR: begin
						col_q <= home_col;
						row_q <= home_row;
					end
					default: begin
					end
				endcase
			end
		end
	end

endmodule
